FILE: design/smlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_pkg: shared types for the motor limit controller
// Item classes, result layout and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package smlc_pkg;

   typedef enum logic [1:0] {
      CLS_CHAR   = 2'd0,
      CLS_LINE   = 2'd1,
      CLS_TICK   = 2'd2,
      CLS_IGNORE = 2'd3
   } item_class_type;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [16:0] NUM_CAP     = 17'd65535;

   localparam logic [0:0] CSR_WATCHDOG  = 1'b0;
   localparam logic [0:0] CSR_HEARTBEAT = 1'b1;

   typedef enum logic [1:0] {
      DIR_BACKWARD = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_OTHER    = 2'd2
   } dir_code_type;

   typedef enum logic [1:0] {
      PH_BLANK = 2'd0,
      PH_SIGN  = 2'd1,
      PH_DIGIT = 2'd2,
      PH_DONE  = 2'd3
   } num_phase_type;

   typedef struct packed {
      item_class_type cls;
      logic [7:0]     rx_byte;
      logic           fwd_limit;
      logic           rev_limit;
   } entry_type;

   typedef struct packed {
      logic       bridge_a;
      logic       bridge_b;
      logic [7:0] pwm_duty;
      logic [1:0] dir_reports;
      logic       heartbeat;
      logic       link_lost;
   } result_type;

endpackage

FILE: design/smlc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_front: byte classifier
// Tracks line length and the zero-byte end, and tags each request as a
// parser character, a line end, a tick, or a dropped byte.
// ----------------------------------------------------------------------------
module smlc_front #(
   parameter int LINE_BUFFER = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                cmd,
   input  logic [7:0]          rx_byte,
   input  logic                fwd_limit,
   input  logic                rev_limit,
   output smlc_pkg::entry_type entry
);
   import smlc_pkg::*;

   localparam int LW = $clog2(LINE_BUFFER);
   localparam logic [LW-1:0] LEN_MAX = LW'(LINE_BUFFER - 1);

   logic [LW-1:0] len_ff, len_in;
   logic          ended_ff, ended_in;

   always_comb begin
      entry.rx_byte   = rx_byte;
      entry.fwd_limit = fwd_limit;
      entry.rev_limit = rev_limit;
      len_in   = len_ff;
      ended_in = ended_ff;
      if (cmd) begin
         entry.cls = CLS_TICK;
      end else if (rx_byte == CHAR_NEWLINE) begin
         entry.cls = CLS_LINE;
         len_in    = '0;
         ended_in  = 1'b0;
      end else if (!ended_ff && len_ff < LEN_MAX) begin
         len_in = len_ff + 1'b1;
         if (rx_byte == 8'h00) begin
            entry.cls = CLS_IGNORE;
            ended_in  = 1'b1;
         end else begin
            entry.cls = CLS_CHAR;
         end
      end else begin
         entry.cls = CLS_IGNORE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         ended_ff <= 1'b0;
      end else if (take) begin
         len_ff   <= len_in;
         ended_ff <= ended_in;
      end
   end

endmodule

FILE: design/smlc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_queue: two-entry queue
// Decouples the classifier from the executor, and the executor from the
// result side.
// ----------------------------------------------------------------------------
module smlc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_en) wp_ff <= ~wp_ff;
         if (rd_en) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_en} - {1'b0, rd_en};
      end
   end

endmodule

FILE: design/smlc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_back: command executor
// Runs the PING match and token parser, the watchdog, the limit logic and
// the heartbeat, and forms one result per request.
// ----------------------------------------------------------------------------
module smlc_back #(
   parameter int TIMER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  smlc_pkg::entry_type  entry,
   input  logic [15:0]          wd_timeout,
   input  logic [15:0]          hb_period,
   output smlc_pkg::result_type result
);
   import smlc_pkg::*;

   localparam logic [TIMER_BITS-1:0] TMAX = '1;

   logic [2:0]    pm_ff, pm_in;
   logic          pb_ff, pb_in;
   logic [1:0]    tok_ff, tok_in;
   logic          open_ff, open_in;
   num_phase_type ph_ff, ph_in;
   logic          neg_ff, neg_in;
   logic [16:0]   val_ff, val_in;
   logic [7:0]    ftv_ff, ftv_in;
   logic          fts_ff, fts_in;
   dir_code_type  stc_ff, stc_in;
   logic          sts_ff, sts_in;
   logic [7:0]    spd_ff, spd_in;
   dir_code_type  dir_ff, dir_in;
   logic          stop_ff, stop_in;
   logic          pf_ff, pf_in, pr_ff, pr_in;
   logic          dead_ff, dead_in;
   logic [TIMER_BITS-1:0] sll_ff, sll_in, shb_ff, shb_in;

   logic [7:0]  c;
   logic        digit, commit, is_ping;
   logic [20:0] mac;
   logic [7:0]  ping_ch;
   logic [1:0]  rep;
   logic        beat;
   logic [7:0]  eff;

   assign c     = entry.rx_byte;
   assign digit = c inside {[8'h30:8'h39]};

   always_comb begin
      case (pm_ff)
         3'd0:    ping_ch = 8'h50;
         3'd1:    ping_ch = 8'h49;
         3'd2:    ping_ch = 8'h4E;
         3'd3:    ping_ch = 8'h47;
         default: ping_ch = 8'h00;
      endcase
   end

   always_comb begin
      pm_in = pm_ff; pb_in = pb_ff; tok_in = tok_ff; open_in = open_ff;
      ph_in = ph_ff; neg_in = neg_ff; val_in = val_ff;
      ftv_in = ftv_ff; fts_in = fts_ff; stc_in = stc_ff; sts_in = sts_ff;
      spd_in = spd_ff; dir_in = dir_ff; stop_in = stop_ff;
      pf_in = pf_ff; pr_in = pr_ff; dead_in = dead_ff;
      sll_in = sll_ff; shb_in = shb_ff;
      commit = 1'b0; rep = 2'd0; beat = 1'b0;
      mac = {4'd0, val_ff} * 21'd10 + {13'd0, c - 8'h30};
      is_ping = !pb_ff && pm_ff == 3'd4;
      case (entry.cls)
         CLS_CHAR: begin
            if (!pb_ff && pm_ff < 3'd4 && c == ping_ch) pm_in = pm_ff + 3'd1;
            else pb_in = 1'b1;
            if (c == CHAR_COLON) begin
               commit = open_ff;
            end else begin
               open_in = 1'b1;
               case (ph_ff)
                  PH_BLANK: begin
                     if (c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
                        ph_in = PH_BLANK;
                     end else if (c == 8'h2B || c == 8'h2D) begin
                        neg_in = c == 8'h2D;
                        ph_in  = PH_SIGN;
                     end else if (digit) begin
                        val_in = {9'd0, c - 8'h30};
                        ph_in  = PH_DIGIT;
                     end else begin
                        ph_in = PH_DONE;
                     end
                  end
                  PH_SIGN, PH_DIGIT: begin
                     if (digit) begin
                        val_in = mac > {4'd0, NUM_CAP} ? NUM_CAP : mac[16:0];
                        ph_in  = PH_DIGIT;
                     end else begin
                        ph_in = PH_DONE;
                     end
                  end
                  default: ph_in = PH_DONE;
               endcase
            end
         end
         CLS_LINE: begin
            commit = open_ff;
         end
         CLS_TICK: begin
            if (!dead_ff && {16'd0, sll_ff} >= {{TIMER_BITS{1'b0}}, wd_timeout}) begin
               dead_in = 1'b1;
               spd_in  = 8'd0;
            end
            sll_in = sll_ff == TMAX ? TMAX : sll_ff + 1'b1;
            if (dir_ff == DIR_FORWARD) begin
               if (entry.fwd_limit) stop_in = 1'b1;
               else if (pf_ff) begin
                  dir_in = DIR_BACKWARD; stop_in = 1'b0; rep[0] = 1'b1;
               end
            end
            if (dir_in == DIR_BACKWARD) begin
               if (entry.rev_limit) stop_in = 1'b1;
               else if (pr_ff) begin
                  dir_in = DIR_FORWARD; stop_in = 1'b0; rep[1] = 1'b1;
               end
            end
            pf_in = entry.fwd_limit;
            pr_in = entry.rev_limit;
            shb_in = shb_ff == TMAX ? TMAX : shb_ff + 1'b1;
            if ({16'd0, shb_in} >= {{TIMER_BITS{1'b0}}, hb_period}) begin
               beat = 1'b1; shb_in = '0;
            end
         end
         default: ;
      endcase

      // Token commit happens at a colon or at the end of the line.
      if (commit) begin
         if (tok_ff == 2'd0) begin
            ftv_in = (neg_ff || val_ff == '0) ? 8'd0 :
                     (val_ff > 17'd255 ? 8'd255 : val_ff[7:0]);
            fts_in = 1'b1;
         end else if (tok_ff == 2'd1) begin
            stc_in = val_ff == '0 ? DIR_BACKWARD :
                     ((!neg_ff && val_ff == 17'd1) ? DIR_FORWARD : DIR_OTHER);
            sts_in = 1'b1;
         end
         if (tok_ff < 2'd2) tok_in = tok_ff + 2'd1;
         open_in = 1'b0; ph_in = PH_BLANK; neg_in = 1'b0; val_in = '0;
      end

      if (entry.cls == CLS_LINE) begin
         if (!is_ping) begin
            if (fts_in) spd_in = ftv_in;
            if (sts_in) dir_in = stc_in;
         end
         sll_in = '0; dead_in = 1'b0;
         pm_in = '0; pb_in = 1'b0; tok_in = '0; open_in = 1'b0;
         ph_in = PH_BLANK; neg_in = 1'b0; val_in = '0;
         ftv_in = '0; fts_in = 1'b0; stc_in = DIR_BACKWARD; sts_in = 1'b0;
      end

      eff = stop_in ? 8'd0 : spd_in;
      result.bridge_a    = eff != 8'd0 && dir_in == DIR_FORWARD;
      result.bridge_b    = eff != 8'd0 && dir_in != DIR_FORWARD;
      result.pwm_duty    = eff == 8'd0 ? 8'd255 : eff;
      result.dir_reports = rep;
      result.heartbeat   = beat;
      result.link_lost   = dead_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff <= '0; pb_ff <= 1'b0; tok_ff <= '0; open_ff <= 1'b0;
         ph_ff <= PH_BLANK; neg_ff <= 1'b0; val_ff <= '0;
         ftv_ff <= '0; fts_ff <= 1'b0; stc_ff <= DIR_BACKWARD; sts_ff <= 1'b0;
         spd_ff <= '0; dir_ff <= DIR_FORWARD; stop_ff <= 1'b0;
         pf_ff <= 1'b0; pr_ff <= 1'b0; dead_ff <= 1'b0;
         sll_ff <= '0; shb_ff <= '0;
      end else if (go) begin
         pm_ff <= pm_in; pb_ff <= pb_in; tok_ff <= tok_in; open_ff <= open_in;
         ph_ff <= ph_in; neg_ff <= neg_in; val_ff <= val_in;
         ftv_ff <= ftv_in; fts_ff <= fts_in; stc_ff <= stc_in; sts_ff <= sts_in;
         spd_ff <= spd_in; dir_ff <= dir_in; stop_ff <= stop_in;
         pf_ff <= pf_in; pr_ff <= pr_in; dead_ff <= dead_in;
         sll_ff <= sll_in; shb_ff <= shb_in;
      end
   end

endmodule

FILE: design/serial_commanded_motor_limit_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_commanded_motor_limit_controller_unit: motor link and limit control
// Serial command parser, link watchdog, end-switch logic and heartbeat.
// ----------------------------------------------------------------------------
// Each request is a serial byte or a 1 ms tick and produces exactly one
// response with the H-bridge drive and status. One request is taken per
// clock while the request queue is not full. The classifier tags the
// request as it is accepted and writes it into a two-entry queue. The
// executor updates all parser and motor state as it takes each entry from
// that queue and writes the response into a second two-entry queue in
// front of the response ports, so requests flow back to back as long as
// responses are popped at the same pace.
module serial_commanded_motor_limit_controller_unit #(
   parameter int LINE_BUFFER = 32,
   parameter int TIMER_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_fwd_limit,
   input  logic        req_rev_limit,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_bridge_a,
   output logic        rsp_bridge_b,
   output logic [7:0]  rsp_pwm_duty,
   output logic [1:0]  rsp_dir_reports,
   output logic        rsp_heartbeat,
   output logic        rsp_link_lost,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import smlc_pkg::*;

   logic [15:0] wd_ff, hb_ff;
   entry_type   fe, be;
   result_type  res, rq;
   logic        take, q_empty, r_full, r_empty, go;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         wd_ff <= 16'd3000;
         hb_ff <= 16'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WATCHDOG:  wd_ff <= csr_data;
            CSR_HEARTBEAT: hb_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign take = push && !full;
   assign go   = !q_empty && !r_full;

   smlc_front #(.LINE_BUFFER(LINE_BUFFER)) u_front (
      .clock, .reset, .take, .cmd(req_cmd), .rx_byte(req_rx_byte),
      .fwd_limit(req_fwd_limit), .rev_limit(req_rev_limit), .entry(fe)
   );

   smlc_queue #(.WIDTH($bits(entry_type))) u_cmdq (
      .clock, .reset, .wr_en(take), .wr_data(fe), .full,
      .rd_en(go), .rd_data(be), .empty(q_empty)
   );

   smlc_back #(.TIMER_BITS(TIMER_BITS)) u_back (
      .clock, .reset, .go, .entry(be), .wd_timeout(wd_ff),
      .hb_period(hb_ff), .result(res)
   );

   smlc_queue #(.WIDTH($bits(result_type))) u_rspq (
      .clock, .reset, .wr_en(go), .wr_data(res), .full(r_full),
      .rd_en(pop && !r_empty), .rd_data(rq), .empty(r_empty)
   );

   assign empty           = r_empty;
   assign rsp_bridge_a    = rq.bridge_a;
   assign rsp_bridge_b    = rq.bridge_b;
   assign rsp_pwm_duty    = rq.pwm_duty;
   assign rsp_dir_reports = rq.dir_reports;
   assign rsp_heartbeat   = rq.heartbeat;
   assign rsp_link_lost   = rq.link_lost;

endmodule

FILE: verif/smlc_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_scoreboard: response checker for the motor limit controller
// Watches the request, response and register channels, keeps its own model of
// the line parser, watchdog, switch logic and heartbeat, and compares every
// response as a whole with the oldest expected one.
// ----------------------------------------------------------------------------
module smlc_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_fwd_limit,
   input  logic        req_rev_limit,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_bridge_a,
   input  logic        rsp_bridge_b,
   input  logic [7:0]  rsp_pwm_duty,
   input  logic [1:0]  rsp_dir_reports,
   input  logic        rsp_heartbeat,
   input  logic        rsp_link_lost,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   import smlc_pkg::*;

   localparam int LINE_MAX = 31;
   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   result_type expected_drive_q[$];

   logic [15:0] wd_limit, hb_period;
   int unsigned line_len, ping_pos, tok_num;
   bit ping_bad, line_done, tok_open, num_neg, first_seen, second_seen;
   num_phase_type num_phase;
   int unsigned num_val, first_val;
   dir_code_type second_code, dir;
   logic [7:0] speed;
   bit limit_stop, prev_fwd, prev_rev, link_dead;
   logic [15:0] since_line, since_beat;

   function automatic void clear_number();
      num_phase = PH_BLANK;
      num_neg = 0;
      num_val = 0;
   endfunction

   function automatic void clear_line();
      line_len = 0;
      ping_pos = 0;
      ping_bad = 0;
      line_done = 0;
      tok_num = 0;
      tok_open = 0;
      clear_number();
      first_val = 0;
      first_seen = 0;
      second_code = DIR_BACKWARD;
      second_seen = 0;
   endfunction

   function automatic void close_token();
      if (tok_num == 0) begin
         first_val = (num_neg || num_val == 0) ? 0 : (num_val > 255 ? 255 : num_val);
         first_seen = 1;
      end else if (tok_num == 1) begin
         if (num_val == 0) second_code = DIR_BACKWARD;
         else if (!num_neg && num_val == 1) second_code = DIR_FORWARD;
         else second_code = DIR_OTHER;
         second_seen = 1;
      end
      if (tok_num < 2) tok_num++;
      tok_open = 0;
      clear_number();
   endfunction

   function automatic void parse_digit_char(logic [7:0] c);
      bit digit;
      int unsigned v;
      digit = (c >= "0" && c <= "9");
      if (num_phase == PH_BLANK) begin
         if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D) begin
         end else if (c == "+" || c == "-") begin
            num_neg = (c == "-");
            num_phase = PH_SIGN;
         end else if (digit) begin
            num_val = c - "0";
            num_phase = PH_DIGIT;
         end else begin
            num_phase = PH_DONE;
         end
      end else if (num_phase != PH_DONE) begin
         if (digit) begin
            v = num_val * 10 + (c - "0");
            num_val = v > NUM_CAP ? NUM_CAP : v;
            num_phase = PH_DIGIT;
         end else begin
            num_phase = PH_DONE;
         end
      end
   endfunction

   function automatic void take_char(logic [7:0] c);
      logic [7:0] ping_text [4];
      ping_text = '{"P", "I", "N", "G"};
      if (!ping_bad && ping_pos < 4 && c == ping_text[ping_pos]) ping_pos++;
      else ping_bad = 1;
      if (c == CHAR_COLON) begin
         if (tok_open) close_token();
      end else begin
         tok_open = 1;
         parse_digit_char(c);
      end
   endfunction

   function automatic void end_line();
      bit is_ping;
      is_ping = !ping_bad && ping_pos == 4;
      if (tok_open) close_token();
      if (!is_ping) begin
         if (first_seen) speed = first_val[7:0];
         if (second_seen) dir = second_code;
      end
      since_line = 0;
      link_dead = 0;
      clear_line();
   endfunction

   function automatic result_type predict_drive(bit tick, logic [7:0] rx, bit f, bit r);
      result_type res;
      logic [1:0] reports;
      bit beat;
      reports = 0;
      beat = 0;
      if (!tick) begin
         if (rx == CHAR_NEWLINE) end_line();
         else if (!line_done && line_len < LINE_MAX) begin
            line_len++;
            if (rx == 8'h00) line_done = 1;
            else take_char(rx);
         end
      end else begin
         if (!link_dead && since_line >= wd_limit) begin
            link_dead = 1;
            speed = 0;
         end
         if (since_line != TIMER_MAX) since_line++;
         if (dir == DIR_FORWARD) begin
            if (f) limit_stop = 1;
            else if (prev_fwd) begin
               dir = DIR_BACKWARD;
               limit_stop = 0;
               reports[0] = 1;
            end
         end
         if (dir == DIR_BACKWARD) begin
            if (r) limit_stop = 1;
            else if (prev_rev) begin
               dir = DIR_FORWARD;
               limit_stop = 0;
               reports[1] = 1;
            end
         end
         prev_fwd = f;
         prev_rev = r;
         if (since_beat != TIMER_MAX) since_beat++;
         if (since_beat >= hb_period) begin
            beat = 1;
            since_beat = 0;
         end
      end
      if (limit_stop || speed == 0) begin
         res.bridge_a = 0;
         res.bridge_b = 0;
         res.pwm_duty = 8'd255;
      end else begin
         res.bridge_a = (dir == DIR_FORWARD);
         res.bridge_b = (dir != DIR_FORWARD);
         res.pwm_duty = speed;
      end
      res.dir_reports = reports;
      res.heartbeat = beat;
      res.link_lost = link_dead;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type seen, want;
      if (reset) begin
         wd_limit <= 16'd3000;
         hb_period <= 16'd1000;
         clear_line();
         speed = 0;
         dir = DIR_FORWARD;
         limit_stop = 0;
         prev_fwd = 0;
         prev_rev = 0;
         link_dead = 0;
         since_line = 0;
         since_beat = 0;
         expected_drive_q.delete();
         fail_count <= 0;
         checked_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WATCHDOG) wd_limit <= csr_data;
            else hb_period <= csr_data;
         end
         if (push && !full)
            expected_drive_q.push_back(predict_drive(req_cmd, req_rx_byte,
                                                     req_fwd_limit, req_rev_limit));
         if (pop && !empty) begin
            seen = '{rsp_bridge_a, rsp_bridge_b, rsp_pwm_duty, rsp_dir_reports,
                     rsp_heartbeat, rsp_link_lost};
            if (expected_drive_q.size() == 0) begin
               $display("%0t: response with none expected, got %p", $time, seen);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_drive_q.pop_front();
               if (seen !== want) begin
                  $display("%0t: response mismatch, expected %p, got %p", $time, want, seen);
                  fail_count <= fail_count + 1;
               end
               checked_count <= checked_count + 1;
            end
         end
      end
      pending_count <= expected_drive_q.size();
   end

endmodule

FILE: verif/tb_serial_commanded_motor_limit_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_commanded_motor_limit_controller_unit: top-level testbench
// Drives command lines, PING lines, noise and ticks with switch patterns
// through the request queue under random stalls and register settings.
// ----------------------------------------------------------------------------
module tb_serial_commanded_motor_limit_controller_unit;
   import smlc_pkg::*;

   logic clock, reset, push, full, req_cmd, req_fwd_limit, req_rev_limit;
   logic [7:0] req_rx_byte;
   logic empty, pop, rsp_bridge_a, rsp_bridge_b, rsp_heartbeat, rsp_link_lost;
   logic [7:0] rsp_pwm_duty;
   logic [1:0] rsp_dir_reports;
   logic csr_valid, csr_ready;
   logic [0:0] csr_index;
   logic [15:0] csr_data;
   int fail_count, pending_count, checked_count;
   int send_idle_pct, take_idle_pct, hold_cycles, cycle_count;
   int request_total;
   bit hold_request, hold_done;

   serial_commanded_motor_limit_controller_unit uut (.*);
   smlc_scoreboard checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("serial_commanded_motor_limit_controller_unit test failed");
            $finish;
         end
      end
   end

   // Response side: random pops, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
         hold_cycles <= 0;
         hold_done <= 0;
      end else if (hold_request && !hold_done) begin
         hold_cycles <= 60;
         hold_done <= 1;
         pop <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         pop <= 0;
      end else begin
         pop <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // The full flag only moves at rising edges, so it is sampled at the
   // falling edge before the edge that may accept the request.
   task automatic send_request(bit tick, logic [7:0] rx, bit f, bit r);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_cmd <= tick;
      req_rx_byte <= rx;
      req_fwd_limit <= f;
      req_rev_limit <= r;
      do begin
         @(negedge clock);
         stalled = full;
         @(posedge clock);
      end while (stalled);
      request_total++;
   endtask

   task automatic send_line(string s);
      for (int i = 0; i < s.len(); i++) send_request(0, s[i], 0, 0);
      send_request(0, CHAR_NEWLINE, 0, 0);
   endtask

   task automatic send_ticks(int n, bit f, bit r);
      repeat (n) send_request(1, 8'($urandom), f, r);
   endtask

   task automatic drain();
      push <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [15:0] val);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   function automatic string random_command();
      string s, t;
      int k;
      k = $urandom_range(9);
      s = $sformatf("%0d:%0d", $urandom_range(300), $urandom_range(2));
      if (k == 0) s = $sformatf(" -%0d: +1", $urandom_range(99999));
      if (k == 1) s = $sformatf("::%0d::x%0d:7", $urandom_range(255), $urandom_range(3));
      if (k == 2) s = $sformatf("%0d", $urandom_range(1, 255));
      if (k == 3) s = "PING";
      if (k == 4) begin
         s = "";
         repeat ($urandom_range(40)) begin
            t = " ";
            t[0] = 8'($urandom_range(1, 255));
            if (t[0] == CHAR_NEWLINE) t[0] = ":";
            s = {s, t};
         end
      end
      return s;
   endfunction

   task automatic random_phase(int n);
      int kind;
      for (int i = 0; i < n;) begin
         kind = $urandom_range(9);
         if (kind < 3) begin
            send_line(random_command());
            i += 6;
         end else if (kind < 5) begin
            send_request(0, 8'($urandom), 1'($urandom), 1'($urandom));
            i++;
         end else begin
            send_ticks(3, $urandom_range(3) == 0, $urandom_range(3) == 0);
            i += 3;
         end
      end
   endtask

   initial begin
      reset = 1;
      push = 0;
      req_cmd = 0;
      req_rx_byte = 0;
      req_fwd_limit = 0;
      req_rev_limit = 0;
      csr_valid = 0;
      csr_index = CSR_WATCHDOG;
      csr_data = 0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      hold_request = 0;
      request_total = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with small register values so the timers fire.
      write_reg(CSR_WATCHDOG, 16'd5);
      write_reg(CSR_HEARTBEAT, 16'd0);
      send_line("200:1");
      send_ticks(2, 1, 0);
      send_ticks(1, 0, 1);
      send_ticks(1, 0, 0);
      send_line("PING");
      send_line("PINGX:0");
      send_line(" +99999 : -0 ");
      send_request(0, 8'h00, 1, 1);
      send_request(0, 8'hFF, 1, 1);
      send_line("");
      send_line("1234567890123456789012345678901:5:1");
      send_ticks(8, 0, 0);

      write_reg(CSR_WATCHDOG, 16'hFFFF);
      write_reg(CSR_HEARTBEAT, 16'hFFFF);
      send_idle_pct = 33;
      take_idle_pct = 63;
      random_phase(170);

      write_reg(CSR_WATCHDOG, 16'd1);
      write_reg(CSR_HEARTBEAT, 16'd3);
      send_idle_pct = 63;
      take_idle_pct = 33;
      random_phase(170);

      write_reg(CSR_WATCHDOG, 16'd40);
      write_reg(CSR_HEARTBEAT, 16'd7);
      send_idle_pct = 0;
      take_idle_pct = 0;
      hold_request = 1;
      random_phase(180);

      drain();
      $display("Run covered %0d requests and %0d checked responses over lines,",
               request_total, checked_count);
      $display("PING, noise, switch ticks and four watchdog/heartbeat settings.");
      if (fail_count == 0) begin
         $display("serial_commanded_motor_limit_controller_unit test passed");
      end else begin
         $display("serial_commanded_motor_limit_controller_unit test failed");
      end
      $finish;
   end

endmodule
